@@ rtl/rwslc_pkg.sv @@
// ----------------------------------------------------------------------------
// rwslc_pkg
// Types and constants of the RIFF/WebP simple lossy container check.
// ----------------------------------------------------------------------------
package rwslc_pkg;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_SHORT    = 4'd1,
    ST_RIFF_TAG = 4'd2,
    ST_WEBP_TAG = 4'd3,
    ST_SIZE     = 4'd4,
    ST_NO_CHUNK = 4'd5,
    ST_CHUNK    = 4'd6,
    ST_OVERRUN  = 4'd7,
    ST_TRAILING = 4'd8
  } status_t;

  // tag bytes, lane n in bits [8n+7:8n]
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WEBP = 32'h5042_4557;
  localparam logic [31:0] TAG_VP8  = 32'h2038_5056;

  localparam int unsigned CNT_W = 33;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [CNT_W-1:0] HDR_LEN   = 33'd12;
  localparam logic [CNT_W-1:0] CHUNK_HDR = 33'd20;
  localparam logic [CNT_W-1:0] RIFF_ADJ  = 33'd8;
  localparam logic [4:0]       PAY_OFS   = 5'd20;

  localparam int unsigned OUT_W = 112;

endpackage

@@ rtl/riff_webp_simple_lossy_check_unit.sv @@
// ----------------------------------------------------------------------------
// riff_webp_simple_lossy_check_unit
// Byte-stream check of a simple lossy RIFF/WebP container header.
// ----------------------------------------------------------------------------
// The file arrives one byte per beat on the in_ channel, in_tlast on its
// final byte. The block counts bytes, checks the tags at offsets 0, 8 and
// 12, and captures the little-endian sizes at offsets 4 and 16.
// For the beat with in_tlast set, one result beat appears on the out_
// channel in the cycle after acceptance. Bytes without in_tlast give no
// result. Throughput is one byte per cycle while no result waits, set by
// the single count-and-compare step between input and result register.
// After a result all state returns to zero and the next byte starts a new
// file. Reset clears the count, the captured sizes, the tag flags and
// out_tvalid. When the receiver stalls, the result is held in the output
// register; input beats are still taken while out_tvalid is low or
// out_tready is high, and held off only while a result waits unaccepted.
// ----------------------------------------------------------------------------
module riff_webp_simple_lossy_check_unit (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [7:0]                in_tdata,   // data_byte[7:0]
  input  logic                      in_tlast,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  // status[3:0], riff_length[35:4], file_length[68:36],
  // payload_offset[73:69], payload_length[105:74], zero[111:106]
  output logic [rwslc_pkg::OUT_W-1:0] out_tdata
);
  import rwslc_pkg::*;

  logic [CNT_W-1:0] byte_count_r, byte_count_nxt, count_inc;
  logic [31:0]      riff_len_r, riff_len_nxt;
  logic [31:0]      chunk_len_r, chunk_len_nxt;
  logic             riff_bad_r, riff_bad_nxt;
  logic             webp_bad_r, webp_bad_nxt;
  logic             chunk_bad_r, chunk_bad_nxt;
  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;
  logic             in_fire;
  logic             in_hdr;
  logic [4:0]       pos;
  logic [1:0]       lane;

  status_t          st;
  logic [31:0]      rl, pl;
  logic [4:0]       po;
  logic [CNT_W-1:0] len;
  logic [CNT_W:0]   riff_sum;
  logic [CNT_W:0]   pay_end;
  logic [CNT_W:0]   pad_end;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign in_hdr    = (byte_count_r < CHUNK_HDR);
  assign pos       = byte_count_r[4:0];
  assign lane      = pos[1:0];
  assign count_inc = (byte_count_r == CNT_MAX) ? byte_count_r : byte_count_r + 1'b1;

  // update the header state with the current byte
  always_comb begin
    riff_len_nxt  = riff_len_r;
    chunk_len_nxt = chunk_len_r;
    riff_bad_nxt  = riff_bad_r;
    webp_bad_nxt  = webp_bad_r;
    chunk_bad_nxt = chunk_bad_r;
    if (in_hdr) begin
      priority if (pos < 5'd4) begin
        if (in_tdata != TAG_RIFF[8*lane +: 8]) riff_bad_nxt = 1'b1;
      end else if (pos < 5'd8) begin
        riff_len_nxt[8*lane +: 8] = in_tdata;
      end else if (pos < 5'd12) begin
        if (in_tdata != TAG_WEBP[8*lane +: 8]) webp_bad_nxt = 1'b1;
      end else if (pos < 5'd16) begin
        if (in_tdata != TAG_VP8[8*lane +: 8]) chunk_bad_nxt = 1'b1;
      end else if (pos < 5'd20) begin
        chunk_len_nxt[8*lane +: 8] = in_tdata;
      end
    end
  end

  // evaluate the checks in order on the updated state
  always_comb begin
    len      = count_inc;
    riff_sum = {2'b00, riff_len_nxt} + {1'b0, RIFF_ADJ};
    pay_end  = {2'b00, chunk_len_nxt} + {1'b0, CHUNK_HDR};
    pad_end  = pay_end + {{CNT_W{1'b0}}, pay_end[0]};
    st = ST_OK;
    rl = '0;
    po = '0;
    pl = '0;
    priority if (len < HDR_LEN) begin
      st = ST_SHORT;
    end else if (riff_bad_nxt) begin
      st = ST_RIFF_TAG;
    end else begin
      rl = riff_len_nxt;
      priority if (webp_bad_nxt) begin
        st = ST_WEBP_TAG;
      end else if (riff_sum != {1'b0, len}) begin
        st = ST_SIZE;
      end else if (len < CHUNK_HDR) begin
        st = ST_NO_CHUNK;
      end else if (chunk_bad_nxt) begin
        st = ST_CHUNK;
      end else if ({1'b0, chunk_len_nxt} > (len - CHUNK_HDR)) begin
        st = ST_OVERRUN;
      end else begin
        po = PAY_OFS;
        pl = chunk_len_nxt;
        st = (pad_end != {1'b0, len}) ? ST_TRAILING : ST_OK;
      end
    end
    out_data_nxt = {6'd0, pl, po, len, rl, st};
  end

  always_comb begin
    byte_count_nxt = byte_count_r;
    if (in_fire) begin
      byte_count_nxt = in_tlast ? '0 : count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_count_r <= '0;
      riff_len_r   <= '0;
      chunk_len_r  <= '0;
      riff_bad_r   <= 1'b0;
      webp_bad_r   <= 1'b0;
      chunk_bad_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      byte_count_r <= byte_count_nxt;
      if (in_fire) begin
        if (in_tlast) begin
          riff_len_r  <= '0;
          chunk_len_r <= '0;
          riff_bad_r  <= 1'b0;
          webp_bad_r  <= 1'b0;
          chunk_bad_r <= 1'b0;
        end else begin
          riff_len_r  <= riff_len_nxt;
          chunk_len_r <= chunk_len_nxt;
          riff_bad_r  <= riff_bad_nxt;
          webp_bad_r  <= webp_bad_nxt;
          chunk_bad_r <= chunk_bad_nxt;
        end
      end
      if (in_fire && in_tlast) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_tlast) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (byte_count_r == '0 && !riff_bad_r && !webp_bad_r
                               && !chunk_bad_r))
    else $error("state not cleared after final byte");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> out_valid_r)
    else $error("no result after final byte");

  a_ready_only_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_valid_r && !out_tready))
    else $error("input held off without an output stall");

  a_ok_has_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r[3:0] == ST_OK)) |-> (out_data_r[73:69] == PAY_OFS))
    else $error("ok status without payload offset");

endmodule
